// ===== hdl/fft_pkg.sv =====
package fft_pkg;
  localparam logic [1:0] CMD_LOAD = 2'd0;
  localparam logic [1:0] CMD_RUN  = 2'd1;
  localparam logic [1:0] CMD_READ = 2'd2;
  localparam logic [1:0] CMD_NOP  = 2'd3;

  localparam longint unsigned PI_Q30 = 64'hC90FDAA2;

  typedef struct packed {
    logic [1:0]         command;
    logic signed [15:0] sample_real;
    logic signed [15:0] sample_imag;
    logic               inverse;
  } fft_in_t;

  typedef struct packed {
    logic signed [31:0] result_real;
    logic signed [31:0] result_imag;
    logic               last;
  } fft_out_t;

  // quarter-wave sine, Q1.15, index 0..256 of a 1024-step circle;
  // integer Taylor series in Q30, rounded half up
  function automatic logic [14:0] quarter_sine(input int m);
    longint unsigned x, term;
    longint          sum, q;
    x = 64'(m) * PI_Q30 / 64'd512;
    term = x;
    sum = longint'(x);
    for (int n = 1; n <= 9; n++) begin
      term = (term * x) >> 30;
      term = ((term * x) >> 30) / 64'((2 * n) * (2 * n + 1));
      if ((n & 1) != 0) sum -= longint'(term);
      else sum += longint'(term);
    end
    q = (sum + 64'sd16384) >>> 15;
    if (q > 64'sd32767) q = 64'sd32767;
    if (q < 64'sd0) q = 64'sd0;
    return q[14:0];
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
    if (v > 34'sd2147483647) return 32'sh7fffffff;
    if (v < -34'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic logic signed [31:0] satq(input logic signed [48:0] v);
    logic signed [48:0] r;
    begin
      r = (v + 49'sd16384) >>> 15;
      if (r > 49'sd2147483647) return 32'sh7fffffff;
      if (r < -49'sd2147483648) return 32'sh80000000;
      return r[31:0];
    end
  endfunction
endpackage

// ===== hdl/fft_if.sv =====
interface fft_in_if;
  import fft_pkg::*;
  logic    valid;
  logic    ready;
  fft_in_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface fft_out_if;
  import fft_pkg::*;
  logic     valid;
  logic     ready;
  fft_out_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== hdl/fft_bfly.sv =====
// Pipelined butterfly: stage 1 forms the complex product, stage 2 the sum and difference.
module fft_bfly import fft_pkg::*; (
  input  logic               clk_i,
  input  logic signed [31:0] ar_i, ai_i, br_i, bi_i,
  input  logic signed [15:0] wr_i, wi_i,
  output logic signed [31:0] xr_o, xi_o, yr_o, yi_o
);
  logic signed [47:0] p0_q, p1_q, p2_q, p3_q;
  logic signed [31:0] ar_q, ai_q;
  logic signed [31:0] tr, ti;
  always_ff @(posedge clk_i) begin
    p0_q <= br_i * wr_i;
    p1_q <= bi_i * wi_i;
    p2_q <= br_i * wi_i;
    p3_q <= bi_i * wr_i;
    ar_q <= ar_i;
    ai_q <= ai_i;
  end
  assign tr = satq({p0_q[47], p0_q} - {p1_q[47], p1_q});
  assign ti = satq({p2_q[47], p2_q} + {p3_q[47], p3_q});
  always_ff @(posedge clk_i) begin
    xr_o <= sat32({{2{ar_q[31]}}, ar_q} + {{2{tr[31]}}, tr});
    xi_o <= sat32({{2{ai_q[31]}}, ai_q} + {{2{ti[31]}}, ti});
    yr_o <= sat32({{2{ar_q[31]}}, ar_q} - {{2{tr[31]}}, tr});
    yi_o <= sat32({{2{ai_q[31]}}, ai_q} - {{2{ti[31]}}, ti});
  end
endmodule

// ===== hdl/radix2_fft_engine.sv =====
// Radix-2 DIT FFT engine, in place, one shared butterfly unit.
// in_if carries commands: load sample, run transform, read result.
// out_if returns one result per read command, last set at index L-1.
// A load stores the sample at the bit-reversed address.
// A read passes through the memory read register and the output register.
// In a run, each butterfly reads a, reads b, waits out the
// two-stage butterfly and writes both results through the single
// write port of the store; the inverse adds a scale pass
// and a mirror pass over the same port.
// in ready is low while a command is in progress or a result waits.
// A stalled receiver holds the result and the block.
// log2_length is written via cfg_we_i; values are clamped to 1..10 and
// to MAX_POINTS. A write or a run resets both pointers.
// Reset clears the sequencer and pointers; the store is undefined until loaded.
module radix2_fft_engine import fft_pkg::*; #(
  parameter int MAX_POINTS = 1024
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [3:0] cfg_wdata_i,
  fft_in_if.sink     in_if,
  fft_out_if.source  out_if
);
  // largest power of two that fits MAX_POINTS, capped at 1024
  localparam int LMAX = (MAX_POINTS >= 1024) ? 10 : $clog2(MAX_POINTS + 1) - 1;
  localparam int AW = LMAX;
  localparam int DEPTH = 1 << LMAX;

  localparam logic [4:0] S_IDLE = 5'd0, S_RD = 5'd1, S_RD2 = 5'd2, S_OUT = 5'd3,
    S_BA = 5'd4, S_BB = 5'd5, S_BW1 = 5'd6, S_BW2 = 5'd7, S_BWA = 5'd8,
    S_BWB = 5'd9, S_SC = 5'd10, S_SCW = 5'd11, S_MA = 5'd12, S_MB = 5'd13,
    S_MWA = 5'd14, S_MWB = 5'd15, S_BW3 = 5'd16;

  logic [4:0]  state_q, state_d;
  logic [3:0]  lg_q;
  logic [3:0]  e;
  logic [10:0] lp_q, rp_q;
  logic        inv_q;
  logic [3:0]  stg_q;
  logic [9:0]  idx_q;
  logic [9:0]  len_m1;
  logic signed [31:0] mr [DEPTH];
  logic signed [31:0] mi [DEPTH];
  logic signed [31:0] rr_q, ri_q, ar_q, ai_q, br_q, bi_q;
  logic signed [31:0] xr, xi, yr, yi;
  logic [AW-1:0] raddr, waddr, wa_q, wb_q;
  logic          we;
  logic signed [31:0] wdr, wdi;
  logic [9:0]  a_addr, b_addr, h, twid, lp_rev, mj;
  logic signed [15:0] wr_q, wi_q;
  fft_out_t    out_q;
  logic        ov_q;
  logic [14:0] qs_rom [257];

  for (genvar g = 0; g <= 256; g++) begin : g_qs
    localparam logic [14:0] QS = quarter_sine(g);
    assign qs_rom[g] = QS;
  end

  function automatic logic signed [15:0] twiddle(input logic [9:0] t);
    logic [14:0] v;
    logic [9:0]  i;
    begin
      if (t < 10'd256) i = t;
      else if (t < 10'd512) i = 10'd512 - t;
      else if (t < 10'd768) i = t - 10'd512;
      else i = 10'd0 - t;
      v = qs_rom[i[8:0]];
      if (t < 10'd512) return $signed({1'b0, v});
      return -$signed({1'b0, v});
    end
  endfunction

  always_comb begin
    e = (lg_q < 4'd1) ? 4'd1 : (lg_q > 4'(LMAX)) ? 4'(LMAX) : lg_q;
  end
  assign len_m1 = 10'((11'd1 << e) - 11'd1);
  assign h = 10'(10'd1 << stg_q);
  // butterfly number idx splits into group (high bits) and offset k (low bits)
  always_comb begin
    logic [9:0] k;
    k = idx_q & (h - 10'd1);
    a_addr = ((idx_q & ~(h - 10'd1)) << 1) | k;
    b_addr = a_addr + h;
    twid = 10'(k << (4'd9 - stg_q));
  end
  always_comb begin
    lp_rev = '0;
    for (int b = 0; b < 10; b++) begin
      if (b < e) lp_rev[e - 4'd1 - 4'(b)] = lp_q[b];
    end
  end
  // mirror partner of index i is L - i
  assign mj = len_m1 - idx_q + 10'd1;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mr[waddr] <= wdr;
      mi[waddr] <= wdi;
    end
    rr_q <= mr[raddr];
    ri_q <= mi[raddr];
  end

  fft_bfly u_bfly (
    .clk_i, .ar_i(ar_q), .ai_i(ai_q), .br_i(br_q), .bi_i(bi_q),
    .wr_i(wr_q), .wi_i(wi_q), .xr_o(xr), .xi_o(xi), .yr_o(yr), .yi_o(yi)
  );

  always_comb begin
    raddr = '0;
    waddr = '0;
    we = 1'b0;
    wdr = '0;
    wdi = '0;
    case (state_q)
      S_IDLE: begin
        raddr = AW'(rp_q[9:0] & len_m1);
        waddr = AW'(lp_rev);
        wdr = 32'(in_if.data.sample_real);
        wdi = 32'(in_if.data.sample_imag);
        we = in_if.valid && in_if.ready && in_if.data.command == CMD_LOAD;
      end
      S_BA: raddr = AW'(a_addr);
      S_BB: raddr = AW'(b_addr);
      S_BWA: begin we = 1'b1; waddr = wa_q; wdr = xr; wdi = xi; end
      S_BWB: begin we = 1'b1; waddr = wb_q; wdr = yr; wdi = yi; end
      S_SC: raddr = AW'(idx_q);
      S_SCW: begin
        we = 1'b1; waddr = AW'(idx_q);
        wdr = rr_q >>> e; wdi = ri_q >>> e;
      end
      S_MA: raddr = AW'(idx_q);
      S_MB: raddr = AW'(mj);
      S_MWA: begin we = 1'b1; waddr = AW'(idx_q); wdr = rr_q; wdi = ri_q; end
      S_MWB: begin we = 1'b1; waddr = AW'(mj); wdr = ar_q; wdi = ai_q; end
      default: ;
    endcase
  end

  assign in_if.ready = (state_q == S_IDLE) && !ov_q;
  assign out_if.valid = ov_q;
  assign out_if.data = out_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (in_if.valid && in_if.ready) begin
        if (in_if.data.command == CMD_READ) state_d = S_RD2;
        else if (in_if.data.command == CMD_RUN) state_d = S_BA;
      end
      S_RD: state_d = S_RD2;
      S_RD2: state_d = S_OUT;
      S_OUT: state_d = S_IDLE;
      S_BA: state_d = S_BB;
      S_BB: state_d = S_BW1;
      S_BW1: state_d = S_BW2;
      S_BW2: state_d = S_BW3;
      S_BW3: state_d = S_BWA;
      S_BWA: state_d = S_BWB;
      S_BWB: begin
        if (idx_q == (len_m1 >> 1)) begin
          if (stg_q == e - 4'd1) state_d = inv_q ? S_SC : S_IDLE;
          else state_d = S_BA;
        end else state_d = S_BA;
      end
      S_SC: state_d = S_SCW;
      S_SCW: state_d = (idx_q == len_m1) ? S_MA : S_SC;
      S_MA: state_d = S_MB;
      S_MB: state_d = S_MWA;
      S_MWA: state_d = S_MWB;
      S_MWB: state_d = (idx_q + 10'd1 < mj - 10'd1) ? S_MA : S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      lg_q <= 4'd10;
      lp_q <= '0;
      rp_q <= '0;
      ov_q <= 1'b0;
      inv_q <= 1'b0;
      stg_q <= '0;
      idx_q <= '0;
    end else begin
      state_q <= state_d;
      if (ov_q && out_if.ready) ov_q <= 1'b0;
      if (cfg_we_i) begin
        lg_q <= cfg_wdata_i;
        lp_q <= '0;
        rp_q <= '0;
      end
      case (state_q)
        S_IDLE: if (in_if.valid && in_if.ready) begin
          if (in_if.data.command == CMD_LOAD)
            lp_q <= 11'((lp_q[9:0] + 10'd1) & len_m1);
          else if (in_if.data.command == CMD_RUN) begin
            inv_q <= in_if.data.inverse;
            stg_q <= '0;
            idx_q <= '0;
            lp_q <= '0;
            rp_q <= '0;
          end else if (in_if.data.command == CMD_READ) begin
            out_q.last <= (rp_q[9:0] & len_m1) == len_m1;
            rp_q <= 11'((rp_q[9:0] + 10'd1) & len_m1);
          end
        end
        S_RD2: begin
          out_q.result_real <= rr_q;
          out_q.result_imag <= ri_q;
          ov_q <= 1'b1;
        end
        S_BA: begin
          wa_q <= AW'(a_addr);
          wb_q <= AW'(b_addr);
          wr_q <= twiddle(twid + 10'd256);
          wi_q <= twiddle(twid);
        end
        S_BB: begin ar_q <= rr_q; ai_q <= ri_q; end
        S_BW1: begin br_q <= rr_q; bi_q <= ri_q; end
        S_BWB: begin
          if (idx_q == (len_m1 >> 1)) begin
            idx_q <= '0;
            stg_q <= stg_q + 4'd1;
          end else idx_q <= idx_q + 10'd1;
        end
        S_SCW: idx_q <= (idx_q == len_m1) ? 10'd1 : idx_q + 10'd1;
        S_MB: begin ar_q <= rr_q; ai_q <= ri_q; end
        S_MWB: idx_q <= idx_q + 10'd1;
        default: ;
      endcase
    end
  end
endmodule

// ===== hdl/fft_checker.sv =====
module fft_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_i,
  input logic out_valid_i,
  input logic out_ready_i
);
  a_no_ready_with_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> !in_ready_i) else $error("input ready while result pending");
  a_out_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i) else $error("result dropped");
  a_busy_after: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> ##1 !out_valid_i || !in_ready_i)
    else $error("ready during result");
endmodule

bind radix2_fft_engine fft_checker u_chk (
  .clk_i, .rst_ni, .in_valid_i(in_if.valid), .in_ready_i(in_if.ready),
  .out_valid_i(out_if.valid), .out_ready_i(out_if.ready)
);
